// File: hdl/pftc_pkg.sv
// ----------------------------------------------------------------------------
// pftc_pkg
// Shared types and constants of the per-flow byte counter table.
// ----------------------------------------------------------------------------
package pftc_pkg;

    localparam int ID_W      = 22;
    localparam int BYTES_W   = 16;
    localparam int CNT_W     = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 88;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_COUNTED = 3'd0,
        ST_ZERO_ID = 3'd1,
        ST_FULL    = 3'd2,
        ST_ENTRY   = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENCODE,
        S_UPDATE,
        S_DR_SCAN,
        S_DR_EMIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic lookup;
        logic alloc;
        logic clear;
    } t_cam_cmd;

    typedef struct packed {
        logic hit;
        logic free_any;
        logic any_valid;
        logic valid_at;
        logic above;
    } t_cam_res;

endpackage

// File: hdl/per_flow_byte_counter_table_core.sv
// ----------------------------------------------------------------------------
// per_flow_byte_counter_table_core
// Table of process ids with inbound and outbound byte counters, read and
// cleared by a drain request.
// ----------------------------------------------------------------------------
// usage:
//   slave channel s_axis_*: one request per beat; tuser is the kind (add or
//   drain), tdata carries proc_id, direction and packet size
//   master channel m_axis_*: result beats; tuser is the status, tlast marks
//   the final beat caused by a request
// an add request gives one result after lookup, counter read, write back
// and output; the next request is taken once the block is back in idle
// id zero and empty drain go straight to output, a full table goes
// through lookup and output
// a drain walks the table one slot per cycle over empty slots and takes
// each valid entry through counter memory read, write back and output,
// where it waits while the receiver stalls
// the block works on one request at a time; a new request is taken while
// the last result still sits in the output register
// reset clears all valid bits at once; counter memory contents are unused
// until an entry is created
// when the receiver stalls, the output register holds and the block waits
// with its next result pending
// ----------------------------------------------------------------------------
module per_flow_byte_counter_table_core #(
    parameter int TABLE_ENTRIES = 64,
    parameter int PID_BITS      = 22
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // proc_id[21:0], inbound[22], packet_bytes[38:23], zero pad
    input  logic [pftc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_id[21:0], in_bytes[53:22], out_bytes[85:54], zero pad
    output logic [pftc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int KEY_W = (PID_BITS < pftc_pkg::ID_W) ? PID_BITS : pftc_pkg::ID_W;
    localparam int CW    = pftc_pkg::CNT_W;
    localparam int RAM_W = KEY_W + 2 * CW;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [pftc_pkg::BYTES_W-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + (CW+1)'(b);
        return s[CW] ? '1 : s[CW-1:0];
    endfunction

    pftc_pkg::t_state          r_state, n_state;
    logic [KEY_W-1:0]          r_key, n_key;
    logic                      r_inbound, n_inbound;
    logic [pftc_pkg::BYTES_W-1:0] r_bytes, n_bytes;
    logic [IDX_W-1:0]          r_slot, n_slot;
    logic                      r_fresh, n_fresh;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_more, n_more;
    pftc_pkg::t_status         r_res_status, n_res_status;
    logic [pftc_pkg::ID_W-1:0] r_res_id, n_res_id;
    logic [CW-1:0]             r_res_in, n_res_in;
    logic [CW-1:0]             r_res_out, n_res_out;
    logic                      r_res_last, n_res_last;
    logic                      r_out_valid, n_out_valid;
    pftc_pkg::t_status         r_out_status, n_out_status;
    logic [pftc_pkg::ID_W-1:0] r_out_id, n_out_id;
    logic [CW-1:0]             r_out_in, n_out_in;
    logic [CW-1:0]             r_out_out, n_out_out;
    logic                      r_out_last, n_out_last;

    logic                      accept;
    logic                      in_kind;
    logic [KEY_W-1:0]          in_key;
    logic                      in_inbound;
    logic [pftc_pkg::BYTES_W-1:0] in_bytes;
    logic                      out_free;

    pftc_pkg::t_cam_cmd        cam_cmd;
    pftc_pkg::t_cam_res        cam_res;
    logic [KEY_W-1:0]          cam_key;
    logic [IDX_W-1:0]          cam_idx;
    logic [IDX_W-1:0]          hit_idx;
    logic [IDX_W-1:0]          free_idx;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [RAM_W-1:0]          ram_wdata;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_raddr;
    logic [RAM_W-1:0]          ram_rdata;
    logic [KEY_W-1:0]          rd_key;
    logic [CW-1:0]             rd_in;
    logic [CW-1:0]             rd_out;
    logic [CW-1:0]             base_in;
    logic [CW-1:0]             base_out;

    assign in_kind    = s_axis_tuser[0];
    assign in_key     = s_axis_tdata[KEY_W-1:0];
    assign in_inbound = s_axis_tdata[22];
    assign in_bytes   = s_axis_tdata[38:23];

    assign s_axis_tready = (r_state == pftc_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign rd_in    = ram_rdata[KEY_W +: CW];
    assign rd_out   = ram_rdata[KEY_W+CW +: CW];
    assign base_in  = r_fresh ? '0 : rd_in;
    assign base_out = r_fresh ? '0 : rd_out;

    assign cam_key = (r_state == pftc_pkg::S_IDLE) ? in_key : r_key;

    pftc_cam #(
        .ENTRIES (TABLE_ENTRIES),
        .KEY_W   (KEY_W),
        .IDX_W   (IDX_W)
    ) u_cam (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cam_cmd),
        .i_key      (cam_key),
        .i_idx      (cam_idx),
        .o_res      (cam_res),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx)
    );

    pftc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pftc_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_kind == pftc_pkg::KIND_DRAIN) begin
                        n_state = cam_res.any_valid ? pftc_pkg::S_DR_SCAN : pftc_pkg::S_RESP;
                    end else begin
                        n_state = (in_key == '0) ? pftc_pkg::S_RESP : pftc_pkg::S_ENCODE;
                    end
                end
            end
            pftc_pkg::S_ENCODE: begin
                n_state = (cam_res.hit || cam_res.free_any) ? pftc_pkg::S_UPDATE
                                                            : pftc_pkg::S_RESP;
            end
            pftc_pkg::S_UPDATE:  n_state = pftc_pkg::S_RESP;
            pftc_pkg::S_DR_SCAN: begin
                if (cam_res.valid_at) begin
                    n_state = pftc_pkg::S_DR_EMIT;
                end
            end
            pftc_pkg::S_DR_EMIT: n_state = pftc_pkg::S_RESP;
            pftc_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = r_more ? pftc_pkg::S_DR_SCAN : pftc_pkg::S_IDLE;
                end
            end
            default: n_state = pftc_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_key        = r_key;
        n_inbound    = r_inbound;
        n_bytes      = r_bytes;
        n_slot       = r_slot;
        n_fresh      = r_fresh;
        n_idx        = r_idx;
        n_more       = r_more;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_in     = r_res_in;
        n_res_out    = r_res_out;
        n_res_last   = r_res_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_in     = r_out_in;
        n_out_out    = r_out_out;
        n_out_last   = r_out_last;
        cam_cmd      = '0;
        cam_idx      = r_idx;
        ram_re       = 1'b0;
        ram_raddr    = r_idx;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = '0;

        unique case (r_state)
            pftc_pkg::S_IDLE: begin
                if (accept) begin
                    n_key      = in_key;
                    n_inbound  = in_inbound;
                    n_bytes    = in_bytes;
                    n_idx      = '0;
                    n_more     = 1'b0;
                    n_res_id   = '0;
                    n_res_in   = '0;
                    n_res_out  = '0;
                    n_res_last = 1'b1;
                    if (in_kind == pftc_pkg::KIND_DRAIN) begin
                        n_res_status = pftc_pkg::ST_EMPTY;
                    end else begin
                        n_res_status   = pftc_pkg::ST_ZERO_ID;
                        cam_cmd.lookup = (in_key != '0);
                    end
                end
            end
            pftc_pkg::S_ENCODE: begin
                n_res_id   = pftc_pkg::ID_W'(r_key);
                n_res_in   = '0;
                n_res_out  = '0;
                n_res_last = 1'b1;
                if (cam_res.hit) begin
                    n_slot    = hit_idx;
                    n_fresh   = 1'b0;
                    ram_re    = 1'b1;
                    ram_raddr = hit_idx;
                end else if (cam_res.free_any) begin
                    n_slot        = free_idx;
                    n_fresh       = 1'b1;
                    cam_cmd.alloc = 1'b1;
                    cam_idx       = free_idx;
                end else begin
                    n_res_status = pftc_pkg::ST_FULL;
                end
            end
            pftc_pkg::S_UPDATE: begin
                ram_we       = 1'b1;
                ram_waddr    = r_slot;
                n_res_status = pftc_pkg::ST_COUNTED;
                if (r_inbound) begin
                    ram_wdata = {base_out, sat_add(base_in, r_bytes), r_key};
                end else begin
                    ram_wdata = {sat_add(base_out, r_bytes), base_in, r_key};
                end
            end
            pftc_pkg::S_DR_SCAN: begin
                if (cam_res.valid_at) begin
                    ram_re = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            pftc_pkg::S_DR_EMIT: begin
                n_res_status  = pftc_pkg::ST_ENTRY;
                n_res_id      = pftc_pkg::ID_W'(rd_key);
                n_res_in      = rd_in;
                n_res_out     = rd_out;
                n_res_last    = !cam_res.above;
                n_more        = cam_res.above;
                ram_we        = 1'b1;
                ram_wdata     = {{(2 * CW){1'b0}}, rd_key};
                // entries idle since the previous drain leave the table
                cam_cmd.clear = (rd_in == '0) && (rd_out == '0);
            end
            pftc_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_in     = r_res_in;
                    n_out_out    = r_res_out;
                    n_out_last   = r_res_last;
                    if (r_more) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pftc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_inbound    <= n_inbound;
        r_bytes      <= n_bytes;
        r_slot       <= n_slot;
        r_fresh      <= n_fresh;
        r_idx        <= n_idx;
        r_more       <= n_more;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_in     <= n_res_in;
        r_res_out    <= n_res_out;
        r_res_last   <= n_res_last;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_in     <= n_out_in;
        r_out_out    <= n_out_out;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_out, r_out_in, r_out_id};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_alloc_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cam_cmd.alloc |-> !cam_res.hit && cam_res.free_any)
        else $error("entry allocated although the id was present or table full");

    a_update_after_encode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pftc_pkg::S_UPDATE) |-> ($past(r_state) == pftc_pkg::S_ENCODE))
        else $error("counter update without a preceding lookup");

    a_drain_reads_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pftc_pkg::S_DR_EMIT) |-> cam_res.valid_at)
        else $error("drain emitted a slot that is not valid");
`endif

endmodule

// File: hdl/pftc_ram.sv
// ----------------------------------------------------------------------------
// pftc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pftc_ram #(
    parameter int WIDTH = 86,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/pftc_cam.sv
// ----------------------------------------------------------------------------
// pftc_cam
// Id match array with valid bits: registered match and free vectors, slot
// encoders and occupancy flags used by the drain walk.
// ----------------------------------------------------------------------------
module pftc_cam #(
    parameter int ENTRIES = 64,
    parameter int KEY_W   = 22,
    parameter int IDX_W   = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pftc_pkg::t_cam_cmd  i_cmd,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [IDX_W-1:0]    i_idx,
    output pftc_pkg::t_cam_res  o_res,
    output logic [IDX_W-1:0]    o_hit_idx,
    output logic [IDX_W-1:0]    o_free_idx
);

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_free;
    logic [KEY_W-1:0]   r_key [ENTRIES];
    logic [ENTRIES-1:0] cmp;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            cmp[i] = r_valid[i] && (r_key[i] == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_match <= '0;
            r_free  <= '0;
        end else begin
            if (i_cmd.lookup) begin
                r_match <= cmp;
                r_free  <= ~r_valid;
            end
            if (i_cmd.alloc) begin
                r_valid[i_idx] <= 1'b1;
            end else if (i_cmd.clear) begin
                r_valid[i_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_key[i_idx] <= i_key;
        end
    end

    // ids are unique, so at most one match bit is set and an or-tree encodes it
    always_comb begin
        o_hit_idx  = '0;
        o_free_idx = '0;
        o_res      = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match[i]) begin
                o_hit_idx = o_hit_idx | IDX_W'(i);
            end
            if (r_valid[i] && (i > int'(i_idx))) begin
                o_res.above = 1'b1;
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                o_free_idx = IDX_W'(i);
            end
        end
        o_res.hit       = |r_match;
        o_res.free_any  = |r_free;
        o_res.any_valid = |r_valid;
        o_res.valid_at  = r_valid[i_idx];
    end

`ifndef NO_ASSERTIONS
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_match))
        else $error("more than one table entry matched the id");
`endif

endmodule
